// ===== rtl/core/csha_pkg.sv =====
// shared types and constants for the complex stencil operator block
package csha_pkg;

    localparam int DATA_W    = 32;
    localparam int COORD_W   = 4;
    localparam int SIZE_W    = 5;
    localparam int CIDX_W    = 5;
    localparam int CFG_IDX_W = 2;
    localparam int NCOEF     = 24;
    localparam int NAXCOEF   = 12;
    localparam int NAXCOEF_W = 4;
    localparam int STEP_W    = 5;
    localparam int LAST_STEP = 24;
    localparam int ACC_W     = 80;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);

    localparam logic [SIZE_W-1:0] MIN_SIZE   = 5'd4;
    localparam logic [SIZE_W-1:0] RESET_SIZE = 5'd16;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        REQ_WRITE_POINT = 2'd0,
        REQ_COMPUTE     = 2'd1,
        REQ_WRITE_COEF  = 2'd2,
        REQ_NONE        = 2'd3
    } req_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIAG   = 2'd0,
        CFG_SIZE_X = 2'd1,
        CFG_SIZE_Y = 2'd2,
        CFG_SIZE_Z = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RUN,
        BK_DRAIN
    } back_state_t;

    typedef enum logic [1:0] {
        TK_CENTER,
        TK_PLUS,
        TK_MINUS
    } term_kind_t;

    typedef struct packed {
        req_t                      op;
        logic [COORD_W-1:0]        x;
        logic [COORD_W-1:0]        y;
        logic [COORD_W-1:0]        z;
        logic signed [DATA_W-1:0]  wave_re;
        logic signed [DATA_W-1:0]  wave_im;
        logic signed [DATA_W-1:0]  potential;
        logic [CIDX_W-1:0]         cidx;
        logic signed [DATA_W-1:0]  cval;
    } cmd_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] diag;
        logic [SIZE_W-1:0]        nx;
        logic [SIZE_W-1:0]        ny;
        logic [SIZE_W-1:0]        nz;
    } cfg_bus_t;

endpackage

// ===== rtl/core/csha_if.sv =====
// handshake channels for input items, result items and register writes
interface csha_in_if import csha_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [1:0]               req_type;
    logic [COORD_W-1:0]       pos_x;
    logic [COORD_W-1:0]       pos_y;
    logic [COORD_W-1:0]       pos_z;
    logic signed [DATA_W-1:0] wave_re;
    logic signed [DATA_W-1:0] wave_im;
    logic signed [DATA_W-1:0] potential;
    logic [CIDX_W-1:0]        coeff_index;
    logic signed [DATA_W-1:0] coeff_value;

    modport source (output valid, req_type, pos_x, pos_y, pos_z, wave_re, wave_im,
                    potential, coeff_index, coeff_value, input ready);
    modport sink (input valid, req_type, pos_x, pos_y, pos_z, wave_re, wave_im,
                  potential, coeff_index, coeff_value, output ready);
endinterface

interface csha_out_if import csha_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [COORD_W-1:0]       out_x;
    logic [COORD_W-1:0]       out_y;
    logic [COORD_W-1:0]       out_z;
    logic signed [DATA_W-1:0] result_re;
    logic signed [DATA_W-1:0] result_im;
    logic                     saturated;

    modport source (output valid, out_x, out_y, out_z, result_re, result_im, saturated,
                    input ready);
    modport sink (input valid, out_x, out_y, out_z, result_re, result_im, saturated,
                  output ready);
endinterface

interface csha_cfg_if import csha_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/csha_front.sv =====
// front end: config registers, item decode and coordinate wrap
module csha_front import csha_pkg::*; #(
    parameter int MAX_NX = 16,
    parameter int MAX_NY = 16,
    parameter int MAX_NZ = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    csha_in_if.sink    in_ch,
    csha_cfg_if.sink   cfg_ch,
    output cfg_bus_t   cfg_bus,
    output logic       push_valid,
    input  logic       push_ready,
    output cmd_t       push_data
);

    logic signed [DATA_W-1:0] diag_reg;
    logic [SIZE_W-1:0]        size_x_reg;
    logic [SIZE_W-1:0]        size_y_reg;
    logic [SIZE_W-1:0]        size_z_reg;
    req_t                     req;

    function automatic logic [SIZE_W-1:0] clamp_n(input logic [SIZE_W-1:0] s, input int maxv);
        logic [SIZE_W-1:0] r;
        r = s;
        if (s < MIN_SIZE)
            r = MIN_SIZE;
        else if (int'(s) > maxv)
            r = SIZE_W'(maxv);
        return r;
    endfunction

    function automatic logic [COORD_W-1:0] wrap(input logic [COORD_W-1:0] p,
                                                 input logic [SIZE_W-1:0] n);
        logic [SIZE_W-1:0] c;
        c = {1'b0, p};
        for (int i = 0; i < 3; i++)
        begin
            if (c >= n)
                c = c - n;
        end
        return c[COORD_W-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diag_reg   <= '0;
            size_x_reg <= RESET_SIZE;
            size_y_reg <= RESET_SIZE;
            size_z_reg <= RESET_SIZE;
        end
        else if (cfg_ch.valid)
        begin
            unique case (cfg_idx_t'(cfg_ch.index))
                CFG_DIAG:   diag_reg   <= cfg_ch.data;
                CFG_SIZE_X: size_x_reg <= cfg_ch.data[SIZE_W-1:0];
                CFG_SIZE_Y: size_y_reg <= cfg_ch.data[SIZE_W-1:0];
                CFG_SIZE_Z: size_z_reg <= cfg_ch.data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg_ch.ready = 1'b1;

    always_comb
    begin
        cfg_bus.diag = diag_reg;
        cfg_bus.nx   = clamp_n(size_x_reg, MAX_NX);
        cfg_bus.ny   = clamp_n(size_y_reg, MAX_NY);
        cfg_bus.nz   = clamp_n(size_z_reg, MAX_NZ);
    end

    assign req = req_t'(in_ch.req_type);

    // type 3 items and out-of-range coefficient writes are dropped here
    always_comb
    begin
        push_data.op        = req;
        push_data.x         = wrap(in_ch.pos_x, cfg_bus.nx);
        push_data.y         = wrap(in_ch.pos_y, cfg_bus.ny);
        push_data.z         = wrap(in_ch.pos_z, cfg_bus.nz);
        push_data.wave_re   = in_ch.wave_re;
        push_data.wave_im   = in_ch.wave_im;
        push_data.potential = in_ch.potential;
        push_data.cidx      = in_ch.coeff_index;
        push_data.cval      = in_ch.coeff_value;
        push_valid = in_ch.valid && (req != REQ_NONE)
                     && !((req == REQ_WRITE_COEF) && (int'(in_ch.coeff_index) >= NCOEF));
    end

    assign in_ch.ready = push_ready;

endmodule

// ===== rtl/core/csha_queue.sv =====
// short command queue between front and back
module csha_queue import csha_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_data
);

    cmd_t               slot_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W:0]    count_reg;
    logic               do_push;
    logic               do_pop;

    assign push_ready = count_reg != (QPTR_W+1)'(QDEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ===== rtl/core/csha_back.sv =====
// back end: grid stores, coefficient table, stencil sequencer and accumulator
module csha_back import csha_pkg::*; #(
    parameter int MAX_NX = 16,
    parameter int MAX_NY = 16,
    parameter int MAX_NZ = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_bus_t    cfg_bus,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  cmd_t        cmd,
    csha_out_if.source  out_ch
);

    localparam int DEPTH = MAX_NX * MAX_NY * MAX_NZ;
    localparam int AW    = $clog2(DEPTH);

    logic [2*DATA_W-1:0]       wave_mem [DEPTH];
    logic [DATA_W-1:0]         pot_mem  [DEPTH];
    logic [2*DATA_W-1:0]       rd_wave_reg;
    logic [DATA_W-1:0]         rd_pot_reg;

    logic signed [DATA_W-1:0]  lap_reg  [NAXCOEF];
    logic signed [DATA_W-1:0]  grad_reg [NAXCOEF];

    back_state_t               state_reg, state_next;
    logic [STEP_W-1:0]         step_reg, step_next;
    logic [COORD_W-1:0]        cx_reg, cy_reg, cz_reg;

    logic                      v0_reg, v1_reg;
    term_kind_t                kind0_reg, kind1_reg;
    logic signed [DATA_W-1:0]  cl0_reg, dg0_reg;
    logic signed [2*DATA_W:0]  m0_reg, m1_reg;
    logic signed [2*DATA_W-1:0] m2_reg, m3_reg;
    logic signed [ACC_W-1:0]   acc_re_reg, acc_im_reg;

    logic                      out_valid_reg;
    logic [COORD_W-1:0]        ox_reg, oy_reg, oz_reg;
    logic signed [DATA_W-1:0]  ore_reg, oim_reg;
    logic                      osat_reg;

    logic                      start;
    logic                      mem_we;
    logic                      coef_we;
    logic                      issue;
    logic                      load;
    logic [AW-1:0]             mem_addr;
    logic [STEP_W-1:0]         s_m1;
    logic [NAXCOEF_W-1:0]      idx;
    logic                      minus;
    logic [1:0]                axis;
    logic [2:0]                kofs;
    logic [SIZE_W-1:0]         nb_x, nb_y, nb_z;

    logic signed [DATA_W:0]    f_s;
    logic signed [DATA_W-1:0]  re_s, im_s;
    logic signed [ACC_W-1:0]   e0, e1, e2, e3;
    logic                      sat_re, sat_im;
    logic signed [DATA_W-1:0]  fin_re, fin_im;

    function automatic logic [AW-1:0] addr_of(input logic [SIZE_W-1:0] x,
                                              input logic [SIZE_W-1:0] y,
                                              input logic [SIZE_W-1:0] z);
        return AW'(int'(x) * (MAX_NY * MAX_NZ) + int'(y) * MAX_NZ + int'(z));
    endfunction

    function automatic logic [SIZE_W-1:0] nb(input logic [COORD_W-1:0] c,
                                             input logic [SIZE_W-1:0] n,
                                             input logic [2:0] k, input logic neg);
        logic [SIZE_W:0] t;
        if (neg)
            t = {2'b0, c} + {1'b0, n} - {3'b0, k};
        else
            t = {2'b0, c} + {3'b0, k};
        if (t >= {1'b0, n})
            t = t - {1'b0, n};
        return t[SIZE_W-1:0];
    endfunction

    function automatic logic [DATA_W:0] finish(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] rnd;
        logic [ACC_W-25:0]       shr;
        logic [ACC_W-56:0]       top;
        rnd = acc + (ACC_W'(1) <<< 23);
        shr = rnd[ACC_W-1:24];
        top = shr[ACC_W-25:31];
        if ((&top) || !(|top))
            return {1'b0, shr[DATA_W-1:0]};
        return {1'b1, top[ACC_W-56] ? SAT_MIN : SAT_MAX};
    endfunction

    // step 0 reads the centre, then +k and -k per axis and offset
    always_comb
    begin
        s_m1  = step_reg - 1'b1;
        idx   = s_m1[NAXCOEF_W:1];
        minus = s_m1[0];
        axis  = idx[3:2];
        kofs  = {1'b0, idx[1:0]} + 3'd1;
        nb_x  = {1'b0, cx_reg};
        nb_y  = {1'b0, cy_reg};
        nb_z  = {1'b0, cz_reg};
        if (step_reg != '0)
        begin
            if (axis == AXIS_X)
                nb_x = nb(cx_reg, cfg_bus.nx, kofs, minus);
            if (axis == AXIS_Y)
                nb_y = nb(cy_reg, cfg_bus.ny, kofs, minus);
            if (axis == AXIS_Z)
                nb_z = nb(cz_reg, cfg_bus.nz, kofs, minus);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd_ready  = 1'b0;
        start      = 1'b0;
        mem_we     = 1'b0;
        coef_we    = 1'b0;
        issue      = 1'b0;
        load       = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    unique case (cmd.op)
                        REQ_WRITE_POINT: mem_we = 1'b1;
                        REQ_WRITE_COEF:  coef_we = 1'b1;
                        REQ_COMPUTE:
                        begin
                            start      = 1'b1;
                            step_next  = '0;
                            state_next = BK_RUN;
                        end
                        default: ;
                    endcase
                end
            end
            BK_RUN:
            begin
                issue     = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(LAST_STEP))
                    state_next = BK_DRAIN;
            end
            BK_DRAIN:
            begin
                if (!v0_reg && !v1_reg && (!out_valid_reg || out_ch.ready))
                begin
                    load       = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            step_reg      <= '0;
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NAXCOEF; i++)
            begin
                lap_reg[i]  <= '0;
                grad_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            v0_reg    <= issue;
            v1_reg    <= v0_reg;
            if (load)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
            if (coef_we)
            begin
                if (int'(cmd.cidx) < NAXCOEF)
                    lap_reg[cmd.cidx[NAXCOEF_W-1:0]] <= cmd.cval;
                else
                    grad_reg[NAXCOEF_W'(cmd.cidx - CIDX_W'(NAXCOEF))] <= cmd.cval;
            end
        end
    end

    assign mem_addr = (state_reg == BK_RUN) ? addr_of(nb_x, nb_y, nb_z)
                                            : addr_of({1'b0, cmd.x}, {1'b0, cmd.y},
                                                      {1'b0, cmd.z});

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            wave_mem[mem_addr] <= {cmd.wave_im, cmd.wave_re};
            pot_mem[mem_addr]  <= cmd.potential;
        end
        rd_wave_reg <= wave_mem[mem_addr];
        rd_pot_reg  <= pot_mem[mem_addr];
    end

    always_comb
    begin
        re_s = rd_wave_reg[DATA_W-1:0];
        im_s = rd_wave_reg[2*DATA_W-1:DATA_W];
        if (kind0_reg == TK_CENTER)
            f_s = (DATA_W+1)'(cfg_bus.diag) + (DATA_W+1)'(signed'(rd_pot_reg));
        else
            f_s = (DATA_W+1)'(cl0_reg);
    end

    always_comb
    begin
        e0 = ACC_W'(m0_reg);
        e1 = ACC_W'(m1_reg);
        e2 = ACC_W'(m2_reg);
        e3 = ACC_W'(m3_reg);
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cx_reg <= cmd.x;
            cy_reg <= cmd.y;
            cz_reg <= cmd.z;
        end
        kind0_reg <= (step_reg == '0) ? TK_CENTER : (minus ? TK_MINUS : TK_PLUS);
        cl0_reg   <= (step_reg == '0) ? '0 : lap_reg[idx];
        dg0_reg   <= (step_reg == '0) ? '0 : grad_reg[idx];
        kind1_reg <= kind0_reg;
        m0_reg    <= f_s * re_s;
        m1_reg    <= f_s * im_s;
        m2_reg    <= dg0_reg * re_s;
        m3_reg    <= dg0_reg * im_s;
        if (start)
        begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else if (v1_reg)
        begin
            unique case (kind1_reg)
                TK_CENTER:
                begin
                    acc_re_reg <= acc_re_reg + e0;
                    acc_im_reg <= acc_im_reg + e1;
                end
                TK_PLUS:
                begin
                    acc_re_reg <= acc_re_reg - (e0 <<< 7) + (e3 <<< 8);
                    acc_im_reg <= acc_im_reg - (e1 <<< 7) - (e2 <<< 8);
                end
                TK_MINUS:
                begin
                    acc_re_reg <= acc_re_reg - (e0 <<< 7) - (e3 <<< 8);
                    acc_im_reg <= acc_im_reg - (e1 <<< 7) + (e2 <<< 8);
                end
                default: ;
            endcase
        end
    end

    assign {sat_re, fin_re} = finish(acc_re_reg);
    assign {sat_im, fin_im} = finish(acc_im_reg);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ox_reg   <= cx_reg;
            oy_reg   <= cy_reg;
            oz_reg   <= cz_reg;
            ore_reg  <= fin_re;
            oim_reg  <= fin_im;
            osat_reg <= sat_re || sat_im;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.out_x     = ox_reg;
    assign out_ch.out_y     = oy_reg;
    assign out_ch.out_z     = oz_reg;
    assign out_ch.result_re = ore_reg;
    assign out_ch.result_im = oim_reg;
    assign out_ch.saturated = osat_reg;

endmodule

// ===== rtl/core/complex_stencil_hamiltonian_apply_top.sv =====
// top level of the complex stencil operator block
// Load items (grid point or coefficient writes) are taken by the back end while it is idle.
// A compute item holds the back end while it is taken from the queue, then makes
// 25 reads from the single-port wave store (center plus eight neighbors per axis, one
// read per cycle), goes through the multiply and accumulate pipeline, and is rounded
// and registered as the result; that last step waits while an earlier result is still held.
// A four-entry queue lets the input side keep taking items while the back end works,
// and the result register holds a finished item until it is taken.
module complex_stencil_hamiltonian_apply_top import csha_pkg::*; #(
    parameter int MAX_NX = 16,
    parameter int MAX_NY = 16,
    parameter int MAX_NZ = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    csha_in_if.sink     in_ch,
    csha_out_if.source  out_ch,
    csha_cfg_if.sink    cfg_ch
);

    cfg_bus_t cfg_bus;
    logic     push_valid, push_ready;
    cmd_t     push_data;
    logic     pop_valid, pop_ready;
    cmd_t     pop_data;

    csha_front #(
        .MAX_NX (MAX_NX),
        .MAX_NY (MAX_NY),
        .MAX_NZ (MAX_NZ)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .cfg_ch     (cfg_ch),
        .cfg_bus    (cfg_bus),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    csha_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    csha_back #(
        .MAX_NX (MAX_NX),
        .MAX_NY (MAX_NY),
        .MAX_NZ (MAX_NZ)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_bus   (cfg_bus),
        .cmd_valid (pop_valid),
        .cmd_ready (pop_ready),
        .cmd       (pop_data),
        .out_ch    (out_ch)
    );

endmodule

// ===== rtl/core/csha_checker.sv =====
// port-level assertions for the stencil block and their binding
module csha_props import csha_pkg::*; (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic signed [DATA_W-1:0] result_re,
    input logic signed [DATA_W-1:0] result_im,
    input logic                     saturated,
    input logic                     cfg_ready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(result_re) && $stable(result_im)
                                    && $stable(saturated))
        else $error("stalled result changed");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> result_re == SAT_MAX || result_re == SAT_MIN
                                   || result_im == SAT_MAX || result_im == SAT_MIN)
        else $error("saturation flag without clipped value");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("register port not ready");

endmodule

bind complex_stencil_hamiltonian_apply_top csha_props u_csha_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .result_re (out_ch.result_re),
    .result_im (out_ch.result_im),
    .saturated (out_ch.saturated),
    .cfg_ready (cfg_ch.ready)
);
